FILE: src/rtsm_pkg.sv
`timescale 1ns / 1ps
// Package for the resistive touch sample mapper: transfer structs, register
// indexes, state encodings and reset values. No dependencies.
package rtsm_pkg;

	localparam int RAW_W = 12;
	localparam int GUARD_W = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 12;
	localparam int SX_W = 9;
	localparam int SY_W = 8;
	localparam int PH_SAMPLES = 4;

	localparam int SCREEN_W_DEF = 320;
	localparam int SCREEN_H_DEF = 240;
	localparam int SAMPLES_DEF = 4;

	localparam logic [RAW_W-1:0] X_ZERO_RST = 12'd3440;
	localparam logic [RAW_W-1:0] X_EDGE_RST = 12'd370;
	localparam logic [RAW_W-1:0] Y_ZERO_RST = 12'd2870;
	localparam logic [RAW_W-1:0] Y_EDGE_RST = 12'd870;
	localparam logic [RAW_W-1:0] NO_TOUCH_RST = 12'd2700;
	localparam logic [GUARD_W-1:0] GUARD_RST = 8'd18;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_X_ZERO = 3'd0,
		REG_X_EDGE = 3'd1,
		REG_Y_ZERO = 3'd2,
		REG_Y_EDGE = 3'd3,
		REG_NO_TOUCH = 3'd4,
		REG_GUARD = 3'd5
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAP,
		ST_DONE
	} top_state_t;

	typedef enum logic [1:0] {
		LN_IDLE,
		LN_MUL,
		LN_DIV,
		LN_DONE
	} lane_state_t;

	typedef struct packed {
		logic [RAW_W-1:0] xph_s0;
		logic [RAW_W-1:0] xph_s1;
		logic [RAW_W-1:0] xph_s2;
		logic [RAW_W-1:0] xph_s3;
		logic [RAW_W-1:0] yph_s0;
		logic [RAW_W-1:0] yph_s1;
		logic [RAW_W-1:0] yph_s2;
		logic [RAW_W-1:0] yph_s3;
	} in_item_t;

	typedef struct packed {
		logic             touched;
		logic [SX_W-1:0]  screen_x;
		logic [SY_W-1:0]  screen_y;
		logic [RAW_W-1:0] recent_raw_x;
		logic [RAW_W-1:0] recent_raw_y;
	} out_item_t;

endpackage

FILE: src/rtsm_avg.sv
`timescale 1ns / 1ps
// Phase averager: sums the first SAMPLES readings of one drive phase and
// divides by SAMPLES with shifts or a reciprocal multiply. Uses rtsm_pkg.
module rtsm_avg #(
	parameter int SAMPLES = rtsm_pkg::SAMPLES_DEF
) (
	input  logic [rtsm_pkg::PH_SAMPLES-1:0][rtsm_pkg::RAW_W-1:0] samples,
	output logic [rtsm_pkg::RAW_W-1:0]                           avg
);

	localparam int SUM_W = rtsm_pkg::RAW_W + 2;
	localparam logic [16:0] RECIP3 = 17'd43691;

	logic [SUM_W-1:0] sum;
	logic [SUM_W+16:0] prod3;

	always_comb begin
		sum = '0;
		for (int i = 0; i < rtsm_pkg::PH_SAMPLES; i++) begin
			if (i < SAMPLES) begin
				sum = sum + SUM_W'(samples[i]);
			end
		end
	end

	assign prod3 = (SUM_W+17)'(sum) * (SUM_W+17)'(RECIP3);

	always_comb begin
		if (SAMPLES == 1) begin
			avg = sum[rtsm_pkg::RAW_W-1:0];
		end else if (SAMPLES == 2) begin
			avg = sum[rtsm_pkg::RAW_W:1];
		end else if (SAMPLES == 3) begin
			avg = prod3[rtsm_pkg::RAW_W+16:17];
		end else begin
			avg = sum[rtsm_pkg::RAW_W+1:2];
		end
	end

endmodule

FILE: src/rtsm_lane.sv
`timescale 1ns / 1ps
// Axis mapping lane: signed (raw - zero) * TOP / (edge - zero), truncated and
// clamped to 0..TOP, using a radix-2 restoring divider. Uses rtsm_pkg.
module rtsm_lane #(
	parameter int TOP = rtsm_pkg::SCREEN_W_DEF - 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [rtsm_pkg::RAW_W-1:0]  raw,
	input  logic [rtsm_pkg::RAW_W-1:0]  at_zero,
	input  logic [rtsm_pkg::RAW_W-1:0]  at_edge,
	output logic                        done,
	output logic [$clog2(TOP+1)-1:0]    result
);

	localparam int TW = $clog2(TOP + 1);
	localparam int DW = rtsm_pkg::RAW_W + 1;
	localparam int PW = DW + TW + 1;
	localparam int MW = DW + TW;
	localparam int CW = $clog2(MW);
	localparam logic [TW-1:0] TOP_V = TW'(TOP);

	rtsm_pkg::lane_state_t state_q, state_d;

	logic signed [DW-1:0] diff_q, den_q;
	logic [MW-1:0] quo_q;
	logic [rtsm_pkg::RAW_W-1:0] den_mag_q, rem_q;
	logic neg_q, zero_q;
	logic [CW-1:0] cnt_q;

	logic signed [PW-1:0] prod;
	logic [PW-1:0] prod_neg;
	logic [DW-1:0] den_neg;
	logic [rtsm_pkg::RAW_W:0] rem_sh, rem_sub;
	logic ge;

	assign prod = diff_q * $signed({1'b0, TOP_V});
	assign prod_neg = -prod;
	assign den_neg = -den_q;
	assign rem_sh = {rem_q, quo_q[MW-1]};
	assign ge = rem_sh >= {1'b0, den_mag_q};
	assign rem_sub = rem_sh - {1'b0, den_mag_q};

	always_comb begin
		state_d = state_q;
		case (state_q)
			rtsm_pkg::LN_IDLE: begin
				if (start) state_d = rtsm_pkg::LN_MUL;
			end
			rtsm_pkg::LN_MUL: begin
				state_d = rtsm_pkg::LN_DIV;
			end
			rtsm_pkg::LN_DIV: begin
				if (cnt_q == CW'(MW - 1)) state_d = rtsm_pkg::LN_DONE;
			end
			rtsm_pkg::LN_DONE: begin
				if (start) state_d = rtsm_pkg::LN_MUL;
			end
			default: begin
				state_d = rtsm_pkg::LN_IDLE;
			end
		endcase
	end

	always_comb begin
		done = (state_q == rtsm_pkg::LN_DONE);
		if (zero_q || neg_q) begin
			result = '0;
		end else if (quo_q > MW'(TOP_V)) begin
			result = TOP_V;
		end else begin
			result = quo_q[TW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rtsm_pkg::LN_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			diff_q <= $signed({1'b0, raw}) - $signed({1'b0, at_zero});
			den_q <= $signed({1'b0, at_edge}) - $signed({1'b0, at_zero});
		end else if (state_q == rtsm_pkg::LN_MUL) begin
			quo_q <= prod[PW-1] ? prod_neg[MW-1:0] : prod[MW-1:0];
			den_mag_q <= den_q[DW-1] ? den_neg[rtsm_pkg::RAW_W-1:0]
				: den_q[rtsm_pkg::RAW_W-1:0];
			neg_q <= prod[PW-1] ^ den_q[DW-1];
			zero_q <= (den_q == '0);
			rem_q <= '0;
			cnt_q <= '0;
		end else if (state_q == rtsm_pkg::LN_DIV) begin
			rem_q <= ge ? rem_sub[rtsm_pkg::RAW_W-1:0] : rem_sh[rtsm_pkg::RAW_W-1:0];
			quo_q <= {quo_q[MW-2:0], ge};
			cnt_q <= cnt_q + CW'(1);
		end
	end

endmodule

FILE: src/resistive_touch_sample_mapper.sv
`timescale 1ns / 1ps
// Resistive touch sample mapper. A poll tick that reports a touch is mapped by
// the bit-serial dividers in the two axis lanes; a tick in guard or without a
// finger skips them and goes straight to the output register. One tick is in
// work at a time, so the input stalls until the result is loaded for output.
// Reset is asynchronous: configuration registers return to their defaults, guard and stored pair to zero.
module resistive_touch_sample_mapper #(
	parameter int SCREEN_W = rtsm_pkg::SCREEN_W_DEF,
	parameter int SCREEN_H = rtsm_pkg::SCREEN_H_DEF,
	parameter int SAMPLES = rtsm_pkg::SAMPLES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [rtsm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rtsm_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  rtsm_pkg::in_item_t               in_data,
	output logic                             out_valid,
	input  logic                             out_stall,
	output rtsm_pkg::out_item_t              out_data
);

	localparam int XTW = $clog2(SCREEN_W);
	localparam int YTW = $clog2(SCREEN_H);

	logic [rtsm_pkg::RAW_W-1:0] x_zero_q, x_edge_q, y_zero_q, y_edge_q, no_touch_q;
	logic [rtsm_pkg::GUARD_W-1:0] guard_reload_q, guard_q;
	logic [rtsm_pkg::RAW_W-1:0] stored_x_q, stored_y_q;

	rtsm_pkg::top_state_t state_q, state_d;
	logic accept, touch_now, lane_start, out_load;
	logic lane_x_done, lane_y_done;
	logic [XTW-1:0] lane_x_res;
	logic [YTW-1:0] lane_y_res;
	logic [31:0] sx_wide, sy_wide;
	logic [rtsm_pkg::RAW_W-1:0] xa, ya;

	logic pend_touched_q;
	logic [rtsm_pkg::SX_W-1:0] pend_sx_q;
	logic [rtsm_pkg::SY_W-1:0] pend_sy_q;
	logic out_valid_q;
	rtsm_pkg::out_item_t out_data_q;

	rtsm_avg #(.SAMPLES(SAMPLES)) u_avg_x (
		.samples({in_data.xph_s3, in_data.xph_s2, in_data.xph_s1, in_data.xph_s0}),
		.avg(xa)
	);

	rtsm_avg #(.SAMPLES(SAMPLES)) u_avg_y (
		.samples({in_data.yph_s3, in_data.yph_s2, in_data.yph_s1, in_data.yph_s0}),
		.avg(ya)
	);

	// Axes are swapped: the y phase drives screen x and the x phase drives screen y.
	rtsm_lane #(.TOP(SCREEN_W - 1)) u_lane_x (
		.clk(clk),
		.arst_n(arst_n),
		.start(lane_start),
		.raw(ya),
		.at_zero(x_zero_q),
		.at_edge(x_edge_q),
		.done(lane_x_done),
		.result(lane_x_res)
	);

	rtsm_lane #(.TOP(SCREEN_H - 1)) u_lane_y (
		.clk(clk),
		.arst_n(arst_n),
		.start(lane_start),
		.raw(xa),
		.at_zero(y_zero_q),
		.at_edge(y_edge_q),
		.done(lane_y_done),
		.result(lane_y_res)
	);

	assign sx_wide = 32'(lane_x_res);
	assign sy_wide = 32'(lane_y_res);
	assign touch_now = (xa <= no_touch_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			rtsm_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = (guard_q == '0 && touch_now) ? rtsm_pkg::ST_MAP
						: rtsm_pkg::ST_DONE;
				end
			end
			rtsm_pkg::ST_MAP: begin
				if (lane_x_done && lane_y_done) state_d = rtsm_pkg::ST_DONE;
			end
			rtsm_pkg::ST_DONE: begin
				if (out_load) state_d = rtsm_pkg::ST_IDLE;
			end
			default: begin
				state_d = rtsm_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_stall = (state_q != rtsm_pkg::ST_IDLE);
		accept = in_valid && (state_q == rtsm_pkg::ST_IDLE);
		lane_start = accept && (guard_q == '0) && touch_now;
		out_load = (state_q == rtsm_pkg::ST_DONE) && (!out_valid_q || !out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_zero_q <= rtsm_pkg::X_ZERO_RST;
			x_edge_q <= rtsm_pkg::X_EDGE_RST;
			y_zero_q <= rtsm_pkg::Y_ZERO_RST;
			y_edge_q <= rtsm_pkg::Y_EDGE_RST;
			no_touch_q <= rtsm_pkg::NO_TOUCH_RST;
			guard_reload_q <= rtsm_pkg::GUARD_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				rtsm_pkg::REG_X_ZERO: x_zero_q <= cfg_data;
				rtsm_pkg::REG_X_EDGE: x_edge_q <= cfg_data;
				rtsm_pkg::REG_Y_ZERO: y_zero_q <= cfg_data;
				rtsm_pkg::REG_Y_EDGE: y_edge_q <= cfg_data;
				rtsm_pkg::REG_NO_TOUCH: no_touch_q <= cfg_data;
				rtsm_pkg::REG_GUARD: guard_reload_q <= cfg_data[rtsm_pkg::GUARD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rtsm_pkg::ST_IDLE;
			guard_q <= '0;
			stored_x_q <= '0;
			stored_y_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				if (guard_q != '0) begin
					guard_q <= guard_q - rtsm_pkg::GUARD_W'(1);
				end else if (touch_now) begin
					guard_q <= guard_reload_q;
					stored_x_q <= ya;
					stored_y_q <= xa;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pend_touched_q <= lane_start;
			pend_sx_q <= '0;
			pend_sy_q <= '0;
		end else if (state_q == rtsm_pkg::ST_MAP && lane_x_done && lane_y_done) begin
			pend_sx_q <= sx_wide[rtsm_pkg::SX_W-1:0];
			pend_sy_q <= sy_wide[rtsm_pkg::SY_W-1:0];
		end
		if (out_load) begin
			out_data_q.touched <= pend_touched_q;
			out_data_q.screen_x <= pend_sx_q;
			out_data_q.screen_y <= pend_sy_q;
			out_data_q.recent_raw_x <= stored_x_q;
			out_data_q.recent_raw_y <= stored_y_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	a_guard_count: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && guard_q != '0) |=> (guard_q == $past(guard_q) - rtsm_pkg::GUARD_W'(1)))
		else $error("guard did not count down on a guarded tick");

	a_idle_coords: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.touched) |-> (out_data.screen_x == '0 && out_data.screen_y == '0))
		else $error("coordinates nonzero on a tick without touch");

	a_lane_restart: assert property (@(posedge clk) disable iff (!arst_n)
		lane_start |=> (!lane_x_done && !lane_y_done))
		else $error("lane reported done right after start");

	a_map_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rtsm_pkg::ST_MAP) |-> in_stall)
		else $error("input taken while lanes are busy");

endmodule

FILE: bench/resistive_touch_sample_mapper_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for resistive_touch_sample_mapper: a directed table of polls
// and calibration writes, then random phases under varied idling. Depends on rtsm_pkg.
module resistive_touch_sample_mapper_tb;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam logic [rtsm_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [rtsm_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

	typedef struct {
		bit                                 is_cfg;
		logic [rtsm_pkg::CFG_IDX_W-1:0]     reg_idx;
		logic [rtsm_pkg::CFG_DATA_W-1:0]    reg_val;
		rtsm_pkg::in_item_t                 poll;
		bit                                 has_typed;
		rtsm_pkg::out_item_t                typed;
	} step_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [rtsm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [rtsm_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	rtsm_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	rtsm_pkg::out_item_t out_data;

	logic [rtsm_pkg::CFG_DATA_W-1:0] cal [0:5];
	logic [rtsm_pkg::GUARD_W-1:0] guard_left = '0;
	logic [rtsm_pkg::RAW_W-1:0] kept_x = '0;
	logic [rtsm_pkg::RAW_W-1:0] kept_y = '0;

	rtsm_pkg::out_item_t pending_reports[$];
	step_row_t steps[$];
	int idle_pct = 0;
	int stall_pct = 0;
	int polls_sent = 0;
	int directed_polls = 0;
	int reports_seen = 0;
	int touch_count = 0;
	int mismatch_count = 0;
	int settings_count = 0;
	int quiet_cycles = 0;

	resistive_touch_sample_mapper u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic logic [rtsm_pkg::RAW_W-1:0] phase_mean(
			input logic [rtsm_pkg::RAW_W-1:0] a, b, c, d);
		logic [rtsm_pkg::RAW_W+1:0] total;
		total = (rtsm_pkg::RAW_W+2)'(a) + (rtsm_pkg::RAW_W+2)'(b)
			+ (rtsm_pkg::RAW_W+2)'(c) + (rtsm_pkg::RAW_W+2)'(d);
		return total[rtsm_pkg::RAW_W+1:2];
	endfunction

	function automatic int calib_axis(input logic [rtsm_pkg::RAW_W-1:0] raw, at0, atmax,
			input int top);
		int span, v;
		span = int'(atmax) - int'(at0);
		if (span == 0)
			return 0;
		v = (int'(raw) - int'(at0)) * top / span;
		if (v < 0)
			v = 0;
		else if (v > top)
			v = top;
		return v;
	endfunction

	function automatic rtsm_pkg::out_item_t predict_report(input rtsm_pkg::in_item_t p);
		rtsm_pkg::out_item_t r;
		logic [rtsm_pkg::RAW_W-1:0] xa, ya;
		int sx, sy;
		r = '0;
		if (guard_left != 0) begin
			guard_left = guard_left - 1'b1;
		end else begin
			xa = phase_mean(p.xph_s0, p.xph_s1, p.xph_s2, p.xph_s3);
			ya = phase_mean(p.yph_s0, p.yph_s1, p.yph_s2, p.yph_s3);
			if (xa <= cal[rtsm_pkg::REG_NO_TOUCH]) begin
				kept_x = ya;
				kept_y = xa;
				sx = calib_axis(ya, cal[rtsm_pkg::REG_X_ZERO], cal[rtsm_pkg::REG_X_EDGE],
					rtsm_pkg::SCREEN_W_DEF - 1);
				sy = calib_axis(xa, cal[rtsm_pkg::REG_Y_ZERO], cal[rtsm_pkg::REG_Y_EDGE],
					rtsm_pkg::SCREEN_H_DEF - 1);
				r.touched = 1'b1;
				r.screen_x = sx[rtsm_pkg::SX_W-1:0];
				r.screen_y = sy[rtsm_pkg::SY_W-1:0];
				guard_left = cal[rtsm_pkg::REG_GUARD][rtsm_pkg::GUARD_W-1:0];
			end
		end
		r.recent_raw_x = kept_x;
		r.recent_raw_y = kept_y;
		return r;
	endfunction

	function automatic rtsm_pkg::in_item_t poll(
			input logic [rtsm_pkg::RAW_W-1:0] x0, x1, x2, x3, y0, y1, y2, y3);
		return {x0, x1, x2, x3, y0, y1, y2, y3};
	endfunction

	function automatic rtsm_pkg::in_item_t flat(input logic [rtsm_pkg::RAW_W-1:0] x, y);
		return poll(x, x, x, x, y, y, y, y);
	endfunction

	function automatic int near_span(input logic [rtsm_pkg::RAW_W-1:0] a, b);
		int lo, hi;
		lo = (a < b) ? int'(a) : int'(b);
		hi = (a < b) ? int'(b) : int'(a);
		lo = (lo < 64) ? 0 : lo - 64;
		hi = (hi > 4095 - 64) ? 4095 : hi + 64;
		return $urandom_range(hi, lo);
	endfunction

	function automatic logic [rtsm_pkg::RAW_W-1:0] jitter(input int c);
		int j, v;
		j = $urandom_range(0, 16);
		v = c + j - 8;
		if (v < 0)
			v = 0;
		else if (v > 4095)
			v = 4095;
		return v[rtsm_pkg::RAW_W-1:0];
	endfunction

	function automatic rtsm_pkg::in_item_t gen_poll();
		rtsm_pkg::in_item_t p;
		int pick, xc, yc, lim;
		pick = $urandom_range(0, 99);
		if (pick < 15)
			return rtsm_pkg::in_item_t'({$urandom, $urandom, $urandom});
		lim = int'(cal[rtsm_pkg::REG_NO_TOUCH]);
		yc = near_span(cal[rtsm_pkg::REG_X_ZERO], cal[rtsm_pkg::REG_X_EDGE]);
		xc = near_span(cal[rtsm_pkg::REG_Y_ZERO], cal[rtsm_pkg::REG_Y_EDGE]);
		if (pick < 30) begin
			if (lim < 4095)
				xc = $urandom_range(4095, lim + 1);
		end else if (xc > lim) begin
			xc = $urandom_range(lim, 0);
		end
		p.xph_s0 = jitter(xc);
		p.xph_s1 = jitter(xc);
		p.xph_s2 = jitter(xc);
		p.xph_s3 = jitter(xc);
		p.yph_s0 = jitter(yc);
		p.yph_s1 = jitter(yc);
		p.yph_s2 = jitter(yc);
		p.yph_s3 = jitter(yc);
		return p;
	endfunction

	task automatic add_poll(input rtsm_pkg::in_item_t p);
		step_row_t r;
		r = '{default: '0};
		r.poll = p;
		steps.push_back(r);
	endtask

	task automatic add_typed(input rtsm_pkg::in_item_t p, input rtsm_pkg::out_item_t w);
		step_row_t r;
		r = '{default: '0};
		r.poll = p;
		r.has_typed = 1'b1;
		r.typed = w;
		steps.push_back(r);
	endtask

	task automatic add_reg(input logic [rtsm_pkg::CFG_IDX_W-1:0] idx,
			input logic [rtsm_pkg::CFG_DATA_W-1:0] val);
		step_row_t r;
		r = '{default: '0};
		r.is_cfg = 1'b1;
		r.reg_idx = idx;
		r.reg_val = val;
		steps.push_back(r);
	endtask

	task automatic write_reg(input logic [rtsm_pkg::CFG_IDX_W-1:0] idx,
			input logic [rtsm_pkg::CFG_DATA_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		if (idx == rtsm_pkg::REG_GUARD)
			cal[idx] = {{(rtsm_pkg::CFG_DATA_W-rtsm_pkg::GUARD_W){1'b0}},
				val[rtsm_pkg::GUARD_W-1:0]};
		else if (idx < rtsm_pkg::REG_GUARD)
			cal[idx] = val;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic send_item(input rtsm_pkg::in_item_t p, input bit has_typed,
			input rtsm_pkg::out_item_t typed);
		rtsm_pkg::out_item_t want;
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= p;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		want = predict_report(p);
		if (has_typed)
			want = typed;
		pending_reports.push_back(want);
		polls_sent++;
	endtask

	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	always @(posedge clk) begin : report_check
		rtsm_pkg::out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			reports_seen++;
			if (pending_reports.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("Unexpected report: touched=%0d x=%0d y=%0d raw=%0d/%0d",
						out_data.touched, out_data.screen_x, out_data.screen_y,
						out_data.recent_raw_x, out_data.recent_raw_y);
			end else begin
				want = pending_reports.pop_front();
				if (want.touched)
					touch_count++;
				if (out_data.touched !== want.touched || out_data.screen_x !== want.screen_x ||
						out_data.screen_y !== want.screen_y ||
						out_data.recent_raw_x !== want.recent_raw_x ||
						out_data.recent_raw_y !== want.recent_raw_y) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display({"Report %0d differs: expected touched=%0d x=%0d y=%0d ",
							"raw=%0d/%0d, got touched=%0d x=%0d y=%0d raw=%0d/%0d"},
							reports_seen, want.touched, want.screen_x, want.screen_y,
							want.recent_raw_x, want.recent_raw_y,
							out_data.touched, out_data.screen_x, out_data.screen_y,
							out_data.recent_raw_x, out_data.recent_raw_y);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		logic [rtsm_pkg::CFG_DATA_W-1:0] setting [0:5];
		cal[rtsm_pkg::REG_X_ZERO] = rtsm_pkg::X_ZERO_RST;
		cal[rtsm_pkg::REG_X_EDGE] = rtsm_pkg::X_EDGE_RST;
		cal[rtsm_pkg::REG_Y_ZERO] = rtsm_pkg::Y_ZERO_RST;
		cal[rtsm_pkg::REG_Y_EDGE] = rtsm_pkg::Y_EDGE_RST;
		cal[rtsm_pkg::REG_NO_TOUCH] = rtsm_pkg::NO_TOUCH_RST;
		cal[rtsm_pkg::REG_GUARD] = {{(rtsm_pkg::CFG_DATA_W-rtsm_pkg::GUARD_W){1'b0}},
			rtsm_pkg::GUARD_RST};

		// Reset calibration: no finger at full scale and just above the threshold.
		add_typed(flat(12'd4095, 12'd4095),
			rtsm_pkg::out_item_t'{1'b0, 9'd0, 8'd0, 12'd0, 12'd0});
		add_typed(flat(12'd2701, 12'd0),
			rtsm_pkg::out_item_t'{1'b0, 9'd0, 8'd0, 12'd0, 12'd0});
		add_reg(rtsm_pkg::REG_GUARD, 12'd1);
		add_typed(flat(12'd0, 12'd0),
			rtsm_pkg::out_item_t'{1'b1, 9'd319, 8'd239, 12'd0, 12'd0});
		add_typed(flat(12'd0, 12'd0),
			rtsm_pkg::out_item_t'{1'b0, 9'd0, 8'd0, 12'd0, 12'd0});
		// Only the low byte of the guard write counts.
		add_reg(rtsm_pkg::REG_GUARD, 12'hF00);
		add_poll(flat(12'd2700, 12'd370));
		add_poll(poll(12'd2700, 12'd2700, 12'd2700, 12'd2703, 12'd3440, 12'd3440,
			12'd3440, 12'd3440));
		add_poll(poll(12'd2701, 12'd2701, 12'd2701, 12'd2700, 12'd4095, 12'd4095,
			12'd4095, 12'd4095));
		add_poll(poll(12'd4095, 12'd0, 12'd4095, 12'd0, 12'd0, 12'd4095, 12'd0, 12'd4095));
		add_poll(poll(12'hAAA, 12'h555, 12'hAAA, 12'h555, 12'h555, 12'hAAA, 12'h555, 12'hAAA));
		// Zero span on screen x, full range on screen y, writes to unused indexes.
		add_reg(rtsm_pkg::REG_X_ZERO, 12'd2000);
		add_reg(rtsm_pkg::REG_X_EDGE, 12'd2000);
		add_reg(rtsm_pkg::REG_Y_ZERO, 12'd0);
		add_reg(rtsm_pkg::REG_Y_EDGE, 12'd4095);
		add_reg(rtsm_pkg::REG_NO_TOUCH, 12'd4095);
		add_reg(REG_SPARE_A, 12'd0);
		add_reg(REG_SPARE_B, 12'd4095);
		add_typed(flat(12'd4095, 12'd4095),
			rtsm_pkg::out_item_t'{1'b1, 9'd0, 8'd239, 12'd4095, 12'd4095});
		add_typed(flat(12'd0, 12'd0),
			rtsm_pkg::out_item_t'{1'b1, 9'd0, 8'd0, 12'd0, 12'd0});
		add_poll(flat(12'd1234, 12'd2000));
		add_reg(rtsm_pkg::REG_X_ZERO, 12'd0);
		add_reg(rtsm_pkg::REG_X_EDGE, 12'd4095);
		add_reg(rtsm_pkg::REG_NO_TOUCH, 12'd0);
		add_typed(flat(12'd0, 12'd4095),
			rtsm_pkg::out_item_t'{1'b1, 9'd319, 8'd0, 12'd4095, 12'd0});
		add_typed(poll(12'd3, 12'd0, 12'd0, 12'd0, 12'd3, 12'd0, 12'd0, 12'd0),
			rtsm_pkg::out_item_t'{1'b1, 9'd0, 8'd0, 12'd0, 12'd0});
		add_typed(flat(12'd1, 12'd1),
			rtsm_pkg::out_item_t'{1'b0, 9'd0, 8'd0, 12'd0, 12'd0});
		add_reg(rtsm_pkg::REG_Y_ZERO, 12'd4095);
		add_reg(rtsm_pkg::REG_Y_EDGE, 12'd4095);
		add_reg(rtsm_pkg::REG_NO_TOUCH, 12'd4095);
		add_poll(flat(12'd4095, 12'd2048));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (steps[i]) begin
			if (steps[i].is_cfg) begin
				settle();
				write_reg(steps[i].reg_idx, steps[i].reg_val);
			end else begin
				send_item(steps[i].poll, steps[i].has_typed, steps[i].typed);
			end
		end
		directed_polls = polls_sent;

		for (int ph = 0; ph < 8; ph++) begin
			settle();
			idle_pct = 0;
			stall_pct = 0;
			setting[rtsm_pkg::REG_X_ZERO] = rtsm_pkg::CFG_DATA_W'($urandom);
			setting[rtsm_pkg::REG_X_EDGE] = rtsm_pkg::CFG_DATA_W'($urandom);
			setting[rtsm_pkg::REG_Y_ZERO] = rtsm_pkg::CFG_DATA_W'($urandom);
			setting[rtsm_pkg::REG_Y_EDGE] = rtsm_pkg::CFG_DATA_W'($urandom);
			setting[rtsm_pkg::REG_NO_TOUCH] =
				rtsm_pkg::CFG_DATA_W'($urandom_range(4095, 2048));
			setting[rtsm_pkg::REG_GUARD] = {4'($urandom), 8'($urandom_range(3, 0))};
			case (ph)
				0, 4: begin
					setting[rtsm_pkg::REG_X_ZERO] = rtsm_pkg::X_ZERO_RST;
					setting[rtsm_pkg::REG_X_EDGE] = rtsm_pkg::X_EDGE_RST;
					setting[rtsm_pkg::REG_Y_ZERO] = rtsm_pkg::Y_ZERO_RST;
					setting[rtsm_pkg::REG_Y_EDGE] = rtsm_pkg::Y_EDGE_RST;
					setting[rtsm_pkg::REG_NO_TOUCH] = rtsm_pkg::NO_TOUCH_RST;
					setting[rtsm_pkg::REG_GUARD] = (ph == 0) ? 12'd0
						: {4'd0, rtsm_pkg::GUARD_RST};
				end
				2: begin
					setting[rtsm_pkg::REG_X_ZERO] = 12'd0;
					setting[rtsm_pkg::REG_X_EDGE] = 12'd4095;
					setting[rtsm_pkg::REG_Y_ZERO] = 12'd4095;
					setting[rtsm_pkg::REG_Y_EDGE] = 12'd0;
					setting[rtsm_pkg::REG_NO_TOUCH] = 12'd4095;
					setting[rtsm_pkg::REG_GUARD] = 12'd0;
				end
				3: begin
					setting[rtsm_pkg::REG_X_ZERO] = 12'd4095;
					setting[rtsm_pkg::REG_X_EDGE] = 12'd0;
					setting[rtsm_pkg::REG_Y_ZERO] = 12'd0;
					setting[rtsm_pkg::REG_Y_EDGE] = 12'd4095;
					setting[rtsm_pkg::REG_NO_TOUCH] = 12'd0;
				end
				5: begin
					setting[rtsm_pkg::REG_GUARD] = 12'd255;
				end
				6: begin
					setting[rtsm_pkg::REG_X_EDGE] = setting[rtsm_pkg::REG_X_ZERO];
					setting[rtsm_pkg::REG_GUARD] = 12'd1;
				end
				7: begin
					setting[rtsm_pkg::REG_NO_TOUCH] = rtsm_pkg::CFG_DATA_W'($urandom);
				end
				default: begin
				end
			endcase
			for (int r = rtsm_pkg::REG_X_ZERO; r <= rtsm_pkg::REG_GUARD; r++)
				write_reg(rtsm_pkg::CFG_IDX_W'(r), setting[r]);
			if (ph == 7) begin
				write_reg(REG_SPARE_A, rtsm_pkg::CFG_DATA_W'($urandom));
				write_reg(REG_SPARE_B, rtsm_pkg::CFG_DATA_W'($urandom));
			end
			settings_count++;
			case (ph % 4)
				1: idle_pct = 55;
				2: stall_pct = 55;
				3: begin
					idle_pct = 7;
					stall_pct = 7;
				end
				default: begin
				end
			endcase
			repeat ((ph == 5) ? 60 : 110)
				send_item(gen_poll(), 1'b0, '0);
		end

		settle();
		repeat (40) @(posedge clk);
		$display("Covered %0d polls (%0d from the directed table) and %0d reports, %0d touches,",
			polls_sent, directed_polls, reports_seen, touch_count);
		$display("across %0d random calibration settings with sender and receiver idling varied.",
			settings_count);
		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
